### rtl/stq_pkg.sv
`default_nettype none

package stq_pkg;

  // Default number of timer slots.
  localparam int DepthDefault = 16;

  // Most expired entries reported by one tick.
  localparam int MaxReports = 16;

  // Field widths.
  localparam int HandleW = 10;
  localparam int TimeW   = 32;
  localparam int KindW   = 3;
  localparam int ReqW    = 2;
  localparam int HeldW   = 5;

  // Request codes.
  typedef enum logic [ReqW-1:0] {
    REQ_ADD    = 2'd0,
    REQ_DEL    = 2'd1,
    REQ_ADJUST = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  // Result codes.
  typedef enum logic [KindW-1:0] {
    KIND_DONE      = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_EXPIRED   = 3'd3,
    KIND_NONE_DUE  = 3'd4
  } kind_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_CMP,
    ST_DEL_RD,
    ST_DEL_CMP,
    ST_TCK_RD,
    ST_TCK_CMP,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_SHF_RD,
    ST_SHF_WR,
    ST_REPLY
  } state_t;

  // One stored timer.
  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   expire;
  } entry_t;

endpackage

`default_nettype wire

### rtl/stq_ram.sv
`default_nettype none

module stq_ram #(
  parameter int DEPTH = stq_pkg::DepthDefault,
  parameter int AW    = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  wa,
  input  stq_pkg::entry_t wd,
  input  logic [AW-1:0]  ra,
  output stq_pkg::entry_t rd
);
  import stq_pkg::*;

  entry_t mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

`default_nettype wire

### rtl/sorted_timer_queue_core.sv
// Channel   Handshake                Fields
// request   start, busy              req_type, entry_handle, new_expire, now_time
// reply     reply_valid (one cycle)  reply_kind, reply_handle, reply_expire,
//                                    entries_held, last_of_run
//
// An item is taken when start is high and busy is low; busy stays high until
// every reply of that item has been shown and the slot store is settled.
// All work goes through one slot memory with one write and one registered read
// port, so every visited slot takes a read state and then a compare or write
// state. Add walks back from the end, moving later entries up, and stops at
// the new place; delete scans every held slot, and adjust is a delete followed
// by an add. Tick counts due entries from the front up to the report limit,
// then reports them and closes the gap; with nothing due it ends after one reply.
// Reset (rst, synchronous) empties the queue at once; slot contents are not
// cleared. The receiver cannot stall: each reply shows for exactly one cycle.
`default_nettype none

module sorted_timer_queue_core #(
  parameter int DEPTH = stq_pkg::DepthDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [stq_pkg::ReqW-1:0]    req_type,
  input  logic [stq_pkg::HandleW-1:0] entry_handle,
  input  logic [stq_pkg::TimeW-1:0]   new_expire,
  input  logic [stq_pkg::TimeW-1:0]   now_time,
  output logic                       reply_valid,
  output logic [stq_pkg::KindW-1:0]   reply_kind,
  output logic [stq_pkg::HandleW-1:0] reply_handle,
  output logic [stq_pkg::TimeW-1:0]   reply_expire,
  output logic [stq_pkg::HeldW-1:0]   entries_held,
  output logic                       last_of_run
);
  import stq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t             state, state_next;
  req_t               req_q;
  logic [HandleW-1:0] hdl_q;
  logic [TimeW-1:0]   exp_q;
  logic [TimeW-1:0]   now_q;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      count;
  logic [CW-1:0]      due;
  logic               found;
  kind_t              res_kind;
  logic [HandleW-1:0] res_hdl;
  logic [TimeW-1:0]   res_exp;

  logic               ram_we;
  logic [AW-1:0]      ram_wa;
  entry_t             ram_wd;
  logic [AW-1:0]      ram_ra;
  entry_t             ram_rd;

  logic [CW-1:0]      idx_dec;
  logic [CW-1:0]      idx_inc;
  logic [CW-1:0]      idx_back;
  logic [CW-1:0]      count_left;
  logic [31:0]        held_full;
  logic [31:0]        left_full;
  logic               at_end;
  logic               at_max;
  logic               later;
  logic               is_due;
  logic               emit_last;

  stq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  // Shared pointer arithmetic and compares.
  assign idx_dec    = idx - 1'b1;
  assign idx_inc    = idx + 1'b1;
  assign idx_back   = idx - due;
  assign count_left = count - due;
  assign held_full  = 32'(count);
  assign left_full  = 32'(count_left);
  assign at_end     = (idx == count);
  assign at_max     = (32'(idx) >= 32'(MaxReports));
  assign later      = (ram_rd.expire > exp_q);
  assign is_due     = (ram_rd.expire <= now_q);
  assign emit_last  = (idx_inc == due);
  assign busy       = (state != ST_IDLE);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req_t'(req_type))
            REQ_ADD:                state_next = (count >= CW'(DEPTH)) ? ST_REPLY : ST_ADD_RD;
            REQ_DEL, REQ_ADJUST:    state_next = ST_DEL_RD;
            REQ_TICK:               state_next = ST_TCK_RD;
            default:                state_next = ST_IDLE;
          endcase
        end
      end
      ST_ADD_RD:  state_next = (idx == '0) ? ST_REPLY : ST_ADD_CMP;
      ST_ADD_CMP: state_next = later ? ST_ADD_RD : ST_REPLY;
      ST_DEL_RD: begin
        if (at_end) begin
          state_next = (found && req_q == REQ_ADJUST) ? ST_ADD_RD : ST_REPLY;
        end else begin
          state_next = ST_DEL_CMP;
        end
      end
      ST_DEL_CMP: state_next = ST_DEL_RD;
      ST_TCK_RD: begin
        if (at_end || at_max) begin
          state_next = (idx == '0) ? ST_REPLY : ST_EMIT_RD;
        end else begin
          state_next = ST_TCK_CMP;
        end
      end
      ST_TCK_CMP: begin
        if (is_due) begin
          state_next = ST_TCK_RD;
        end else begin
          state_next = (idx == '0) ? ST_REPLY : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD:  state_next = ST_EMIT_OUT;
      ST_EMIT_OUT: state_next = emit_last ? ST_SHF_RD : ST_EMIT_RD;
      ST_SHF_RD:   state_next = at_end ? ST_IDLE : ST_SHF_WR;
      ST_SHF_WR:   state_next = ST_SHF_RD;
      ST_REPLY:    state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Memory port control.
  always_comb begin
    ram_we = 1'b0;
    ram_wa = idx[AW-1:0];
    ram_wd = ram_rd;
    ram_ra = idx[AW-1:0];
    unique case (state)
      ST_ADD_RD: begin
        ram_ra = idx_dec[AW-1:0];
        if (idx == '0) begin
          ram_we = 1'b1;
          ram_wd = '{handle: hdl_q, expire: exp_q};
        end
      end
      ST_ADD_CMP: begin
        ram_we = 1'b1;
        if (!later) begin
          ram_wd = '{handle: hdl_q, expire: exp_q};
        end
      end
      ST_DEL_CMP: begin
        ram_we = found;
        ram_wa = idx_dec[AW-1:0];
      end
      ST_SHF_WR: begin
        ram_we = 1'b1;
        ram_wa = idx_back[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Reply ports.
  always_comb begin
    reply_valid  = 1'b0;
    reply_kind   = res_kind;
    reply_handle = res_hdl;
    reply_expire = res_exp;
    entries_held = held_full[HeldW-1:0];
    last_of_run  = 1'b0;
    unique case (state)
      ST_REPLY: begin
        reply_valid = 1'b1;
        last_of_run = 1'b1;
      end
      ST_EMIT_OUT: begin
        reply_valid  = 1'b1;
        reply_kind   = KIND_EXPIRED;
        reply_handle = ram_rd.handle;
        reply_expire = ram_rd.expire;
        entries_held = left_full[HeldW-1:0];
        last_of_run  = emit_last;
      end
      default: begin
        reply_valid = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_ADD_RD: begin
          if (idx == '0) begin
            count <= count + 1'b1;
          end
        end
        ST_ADD_CMP: begin
          if (!later) begin
            count <= count + 1'b1;
          end
        end
        ST_DEL_RD: begin
          if (at_end && found) begin
            count <= count - 1'b1;
          end
        end
        ST_SHF_RD: begin
          if (at_end) begin
            count <= count_left;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  // Working registers of the current item.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        req_q <= req_t'(req_type);
        hdl_q <= entry_handle;
        exp_q <= new_expire;
        now_q <= now_time;
        found <= 1'b0;
        idx   <= (req_t'(req_type) == REQ_ADD) ? count : '0;
        res_kind <= KIND_FULL;
        res_hdl  <= entry_handle;
        res_exp  <= new_expire;
      end
      ST_ADD_RD: begin
        if (idx == '0) begin
          res_kind <= KIND_DONE;
          res_hdl  <= hdl_q;
          res_exp  <= exp_q;
        end
      end
      ST_ADD_CMP: begin
        if (later) begin
          idx <= idx_dec;
        end else begin
          res_kind <= KIND_DONE;
          res_hdl  <= hdl_q;
          res_exp  <= exp_q;
        end
      end
      ST_DEL_RD: begin
        if (at_end) begin
          res_hdl <= hdl_q;
          idx     <= count - 1'b1;
          if (found) begin
            res_kind <= KIND_DONE;
          end else begin
            res_kind <= KIND_NOT_FOUND;
            res_exp  <= '0;
          end
        end
      end
      ST_DEL_CMP: begin
        if (!found && ram_rd.handle == hdl_q) begin
          found   <= 1'b1;
          res_exp <= ram_rd.expire;
        end
        idx <= idx_inc;
      end
      ST_TCK_RD: begin
        if (at_end || at_max) begin
          due      <= idx;
          idx      <= '0;
          res_kind <= KIND_NONE_DUE;
          res_hdl  <= '0;
          res_exp  <= '0;
        end
      end
      ST_TCK_CMP: begin
        if (is_due) begin
          idx <= idx_inc;
        end else begin
          due      <= idx;
          idx      <= '0;
          res_kind <= KIND_NONE_DUE;
          res_hdl  <= '0;
          res_exp  <= '0;
        end
      end
      ST_EMIT_OUT: idx <= idx_inc;
      ST_SHF_WR:   idx <= idx_inc;
      default: begin
        idx <= idx;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/stq_checker.sv
`default_nettype none

module stq_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       reply_valid,
  input logic [stq_pkg::KindW-1:0]   reply_kind,
  input logic [stq_pkg::HandleW-1:0] reply_handle,
  input logic [stq_pkg::TimeW-1:0]   reply_expire,
  input logic                       last_of_run
);
  import stq_pkg::*;

  // Replies only appear while an item is being worked on.
  a_reply_busy: assert property (@(posedge clk) disable iff (rst)
    reply_valid |-> busy)
    else $error("reply shown while idle");

  // A taken item keeps the block busy in the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("item taken but block not busy");

  // A closing reply other than an expiry report ends the item at once.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && last_of_run && reply_kind != KIND_EXPIRED) |=> !busy)
    else $error("block still busy after its last reply");

  // An empty tick gives one bare reply.
  a_none_due: assert property (@(posedge clk) disable iff (rst)
    (reply_valid && reply_kind == KIND_NONE_DUE)
      |-> (last_of_run && reply_handle == '0 && reply_expire == '0))
    else $error("malformed nothing-due reply");

endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .reply_valid  (reply_valid),
  .reply_kind   (reply_kind),
  .reply_handle (reply_handle),
  .reply_expire (reply_expire),
  .last_of_run  (last_of_run)
);

`default_nettype wire

### tb/sv/tb_sorted_timer_queue_core.sv
`timescale 1ns / 100ps

module tb_sorted_timer_queue_core;
  import stq_pkg::*;

  localparam int Depth       = DepthDefault;
  localparam int DrainCycles = 200;
  localparam int RandomItems = 285;
  localparam int ShownErrors = 10;

  // One request as the driver presents it, with the chance of idling before it.
  typedef struct {
    req_t               rq;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   expire;
    logic [TimeW-1:0]   now;
    int                 gap_pct;
  } timer_req_t;

  // One reply as the block shows it.
  typedef struct {
    kind_t              kind;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   expire;
    logic [HeldW-1:0]   held;
    logic               last;
  } timer_reply_t;

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  logic [ReqW-1:0]    req_type     = '0;
  logic [HandleW-1:0] entry_handle = '0;
  logic [TimeW-1:0]   new_expire   = '0;
  logic [TimeW-1:0]   now_time     = '0;
  logic               busy;
  logic               reply_valid;
  logic [KindW-1:0]   reply_kind;
  logic [HandleW-1:0] reply_handle;
  logic [TimeW-1:0]   reply_expire;
  logic [HeldW-1:0]   entries_held;
  logic               last_of_run;

  timer_req_t   queued_requests[$];
  timer_reply_t predicted_replies[$];
  int           mismatches = 0;

  // Our own copy of the sorted timer list.
  logic [HandleW-1:0] list_handle[Depth];
  logic [TimeW-1:0]   list_expire[Depth];
  int                 list_count = 0;

  sorted_timer_queue_core #(
    .DEPTH(Depth)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .entry_handle(entry_handle),
    .new_expire  (new_expire),
    .now_time    (now_time),
    .reply_valid (reply_valid),
    .reply_kind  (reply_kind),
    .reply_handle(reply_handle),
    .reply_expire(reply_expire),
    .entries_held(entries_held),
    .last_of_run (last_of_run)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Close the gap at pos by shifting later entries down.
  task automatic list_remove(input int pos);
    for (int i = pos; i + 1 < list_count; i++) begin
      list_handle[i] = list_handle[i + 1];
      list_expire[i] = list_expire[i + 1];
    end
    list_count--;
  endtask

  // Place a timer after every entry whose expiry is equal or earlier.
  task automatic list_insert(input logic [HandleW-1:0] h, input logic [TimeW-1:0] e);
    int pos;
    pos = 0;
    while (pos < list_count && list_expire[pos] <= e) pos++;
    for (int i = list_count; i > pos; i--) begin
      list_handle[i] = list_handle[i - 1];
      list_expire[i] = list_expire[i - 1];
    end
    list_handle[pos] = h;
    list_expire[pos] = e;
    list_count++;
  endtask

  // Position of the earliest entry with handle h, or -1.
  function automatic int list_find(input logic [HandleW-1:0] h);
    for (int i = 0; i < list_count; i++) begin
      if (list_handle[i] == h) return i;
    end
    return -1;
  endfunction

  function automatic timer_reply_t reply_of(input kind_t k, input logic [HandleW-1:0] h,
                                            input logic [TimeW-1:0] e);
    timer_reply_t r;
    r.kind   = k;
    r.handle = h;
    r.expire = e;
    r.held   = '0;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic string reply_text(input timer_reply_t r);
    return $sformatf("kind %0d handle %0d expire 0x%08h held %0d last %0b",
                     r.kind, r.handle, r.expire, r.held, r.last);
  endfunction

  // Apply one request to the list and queue the replies it causes.
  task automatic predict_replies(input req_t rq, input logic [HandleW-1:0] h,
                                 input logic [TimeW-1:0] e, input logic [TimeW-1:0] now);
    timer_reply_t reps[$];
    int           pos;
    logic [TimeW-1:0] old_expire;
    case (rq)
      REQ_ADD: begin
        if (list_count >= Depth) begin
          reps.push_back(reply_of(KIND_FULL, h, e));
        end else begin
          list_insert(h, e);
          reps.push_back(reply_of(KIND_DONE, h, e));
        end
      end
      REQ_DEL: begin
        pos = list_find(h);
        if (pos < 0) begin
          reps.push_back(reply_of(KIND_NOT_FOUND, h, '0));
        end else begin
          old_expire = list_expire[pos];
          list_remove(pos);
          reps.push_back(reply_of(KIND_DONE, h, old_expire));
        end
      end
      REQ_ADJUST: begin
        pos = list_find(h);
        if (pos < 0) begin
          reps.push_back(reply_of(KIND_NOT_FOUND, h, '0));
        end else begin
          list_remove(pos);
          list_insert(h, e);
          reps.push_back(reply_of(KIND_DONE, h, e));
        end
      end
      default: begin
        while (reps.size() < MaxReports && list_count > 0 && list_expire[0] <= now) begin
          reps.push_back(reply_of(KIND_EXPIRED, list_handle[0], list_expire[0]));
          list_remove(0);
        end
        if (reps.size() == 0) reps.push_back(reply_of(KIND_NONE_DUE, '0, '0));
      end
    endcase
    // Every reply of one request carries the final count; only the last is marked.
    foreach (reps[k]) begin
      reps[k].held = HeldW'(list_count);
      reps[k].last = (k == reps.size() - 1);
      predicted_replies.push_back(reps[k]);
    end
  endtask

  task automatic queue_req(input req_t rq, input logic [HandleW-1:0] h,
                           input logic [TimeW-1:0] e, input logic [TimeW-1:0] now,
                           input int gap);
    timer_req_t it;
    it.rq      = rq;
    it.handle  = h;
    it.expire  = e;
    it.now     = now;
    it.gap_pct = gap;
    queued_requests.push_back(it);
  endtask

  // Random traffic in segments that fill, mix or drain the list, over a moving clock.
  task automatic queue_random_reqs();
    logic [TimeW-1:0]   clock_now;
    logic [HandleW-1:0] h;
    logic [TimeW-1:0]   e;
    logic [TimeW-1:0]   n;
    req_t               rq;
    int                 mode;
    int                 gap;
    int                 r;
    int                 add_w;
    int                 tick_w;
    clock_now = 32'd1000;
    mode = 0;
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 20 == 0) mode = $urandom_range(0, 2);
      // Run late in the random part near the top of the time range so it wraps.
      if (i == 150) clock_now = 32'hFFFF_F000;
      if (i < 70) gap = 0;
      else if (i < 160) gap = 82;
      else if (i < 230) gap = 0;
      else gap = 12;
      r = $urandom_range(0, 99);
      if (r < 6) begin
        // Noise: anything at all, over the full field ranges.
        queue_req(req_t'($urandom_range(0, 3)), HandleW'($urandom), $urandom, $urandom, gap);
      end else begin
        add_w  = (mode == 0) ? 75 : (mode == 1) ? 40 : 15;
        tick_w = (mode == 2) ? 45 : 20;
        r = $urandom_range(0, 99);
        if (r < add_w) rq = REQ_ADD;
        else if (r < add_w + tick_w) rq = REQ_TICK;
        else if (r % 2 == 0) rq = REQ_DEL;
        else rq = REQ_ADJUST;
        h = ($urandom_range(0, 9) == 0) ? HandleW'($urandom) : HandleW'($urandom_range(0, 11));
        // Coarse steps make equal expiries common; a few land in the past.
        if ($urandom_range(0, 9) == 0) e = clock_now - $urandom_range(0, 100);
        else e = clock_now + 8 * $urandom_range(0, 40);
        if ($urandom_range(0, 19) == 0) n = 32'hFFFF_FFFF;
        else n = clock_now + $urandom_range(0, 200);
        queue_req(rq, h, e, n, gap);
        clock_now = clock_now + $urandom_range(0, 60);
      end
    end
  endtask

  // Driver: present the next item once the current one is taken, idling at random.
  always @(posedge clk) begin
    timer_req_t it;
    logic       taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) predict_replies(req_t'(req_type), entry_handle, new_expire, now_time);
      if (!start || taken) begin
        if (queued_requests.size() > 0 &&
            $urandom_range(0, 99) >= queued_requests[0].gap_pct) begin
          it = queued_requests.pop_front();
          start        <= 1'b1;
          req_type     <= it.rq;
          entry_handle <= it.handle;
          new_expire   <= it.expire;
          now_time     <= it.now;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every reply is checked against the oldest prediction.
  always @(posedge clk) begin
    timer_reply_t got;
    timer_reply_t want;
    if (!rst && reply_valid) begin
      got.kind   = kind_t'(reply_kind);
      got.handle = reply_handle;
      got.expire = reply_expire;
      got.held   = entries_held;
      got.last   = last_of_run;
      if (predicted_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors) $display("unexpected reply: %s", reply_text(got));
      end else begin
        want = predicted_replies.pop_front();
        if (got.kind !== want.kind || got.handle !== want.handle ||
            got.expire !== want.expire || got.held !== want.held ||
            got.last !== want.last) begin
          mismatches++;
          if (mismatches <= ShownErrors) begin
            $display("reply mismatch: expected %s", reply_text(want));
            $display("                actual   %s", reply_text(got));
          end
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Empty list: tick with nothing due, delete and adjust of an absent handle.
    queue_req(REQ_TICK, 10'd0, 32'd0, 32'd0, 0);
    queue_req(REQ_DEL, 10'd5, 32'd0, 32'd0, 0);
    queue_req(REQ_ADJUST, 10'd5, 32'd77, 32'd0, 0);
    // Field extremes, a duplicate handle and equal expiries.
    queue_req(REQ_ADD, 10'd0, 32'd0, 32'd0, 0);
    queue_req(REQ_ADD, 10'd1023, 32'hFFFF_FFFF, 32'd0, 0);
    queue_req(REQ_ADD, 10'd7, 32'd100, 32'd0, 0);
    queue_req(REQ_ADD, 10'd7, 32'd100, 32'd0, 0);
    queue_req(REQ_ADD, 10'd9, 32'd100, 32'd0, 0);
    // Adjust to an earlier and to a later expiry, then delete the first duplicate.
    queue_req(REQ_ADJUST, 10'd7, 32'd50, 32'd0, 0);
    queue_req(REQ_ADJUST, 10'd9, 32'hFFFF_FFFF, 32'd0, 0);
    queue_req(REQ_DEL, 10'd7, 32'd0, 32'd0, 0);
    // Tick with only part of the list due.
    queue_req(REQ_TICK, 10'd0, 32'd0, 32'd99, 0);
    // Fill the list, add once more while full, then expire all of it in one tick.
    for (int i = 0; i < 13; i++) begin
      queue_req(REQ_ADD, HandleW'(100 + i), $urandom_range(200, 5000), 32'd0, 0);
    end
    queue_req(REQ_ADD, 10'd512, 32'd300, 32'd0, 0);
    queue_req(REQ_TICK, 10'd0, 32'd0, 32'hFFFF_FFFF, 0);
    queue_random_reqs();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (queued_requests.size() != 0 || start) @(posedge clk);
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake or missing replies.
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/stq_pkg.sv
rtl/stq_ram.sv
rtl/sorted_timer_queue_core.sv
rtl/stq_checker.sv
tb/sv/tb_sorted_timer_queue_core.sv
